### rtl/nearest_masked_texel_fill_defines.svh
// Assertion macros shared by the nearest masked texel fill RTL.
`ifndef NEAREST_MASKED_TEXEL_FILL_DEFINES_SVH
`define NEAREST_MASKED_TEXEL_FILL_DEFINES_SVH

// Check that ante implies cons in the same cycle.
`define NMTF_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("nmtf: same-cycle check failed");

// Check that ante implies cons in the following cycle.
`define NMTF_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("nmtf: next-cycle check failed");

`endif

### rtl/nmtf_pkg.sv
// Shared types and constants for the nearest masked texel fill block.
`timescale 1ns / 1ps
`default_nettype none

package nmtf_pkg;

  // Request command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SEARCH_RADIUS = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;

  // Field widths fixed by the interface
  localparam int POS_W    = 8;
  localparam int COORD_W  = 9;   // window coordinates reach x + r
  localparam int RADIUS_W = 8;
  localparam int DIM_W    = 9;
  localparam int CFG_W    = 9;
  localparam int PORT_CH_W = 32;
  localparam int SQ_W     = 16;  // square of an 8-bit offset
  localparam int DIST_W   = 17;  // sum of two squares

  localparam logic [7:0] FULL_MASK = 8'hff;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd16;
  localparam logic [DIM_W-1:0]    DIM_RESET    = 9'd256;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_texel;      // store the loaded texel
    logic start_query;   // latch position, window and clear the search
    logic read_own;      // read coverage and colour of the queried texel
    logic scan_step;     // read one window texel and advance
    logic fetch_colour;  // read colour of the winner or of the texel itself
  } nmtf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic outside;       // requested position lies beyond the store
    logic covered;       // queried texel is covered
    logic win_empty;     // clipped window holds no texel
    logic scan_last;     // current scan position is the last of the window
  } nmtf_status_t;

endpackage

`default_nettype wire

### rtl/nmtf_ctrl.sv
// Controller state machine that sequences loads, lookups and window scans.
`timescale 1ns / 1ps
`default_nettype none

module nmtf_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire                   command,
  input  nmtf_pkg::nmtf_status_t status,
  output nmtf_pkg::nmtf_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOOKUP = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_FETCH  = 7'b0100000,
    ST_REPLY  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_REPLY);

  // Drive datapath commands
  always_comb begin
    cmd.wr_texel     = accept && (command == nmtf_pkg::CMD_LOAD);
    cmd.start_query  = accept && (command == nmtf_pkg::CMD_QUERY);
    cmd.read_own     = (state == ST_LOOKUP);
    cmd.scan_step    = (state == ST_SCAN);
    cmd.fetch_colour = (state == ST_FETCH);
  end

  // Choose next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (command == nmtf_pkg::CMD_QUERY)) begin
          state_next = status.outside ? ST_REPLY : ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.covered) begin
          state_next = ST_REPLY;
        end else if (status.win_empty) begin
          state_next = ST_FETCH;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FETCH;
      ST_FETCH: state_next = ST_REPLY;
      ST_REPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/nmtf_datapath.sv
// Datapath: texel stores, configuration registers, window scan and nearest pick.
`timescale 1ns / 1ps
`default_nettype none

module nmtf_datapath #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  nmtf_pkg::nmtf_cmd_t                   cmd,
  output nmtf_pkg::nmtf_status_t                status,
  input  wire                                   cfg_write,
  input  wire  [1:0]                            cfg_index,
  input  wire  [nmtf_pkg::CFG_W-1:0]            cfg_data,
  input  wire  [nmtf_pkg::POS_W-1:0]            pos_x,
  input  wire  [nmtf_pkg::POS_W-1:0]            pos_y,
  input  wire  [7:0]                            mask_byte,
  input  wire  [nmtf_pkg::PORT_CH_W-1:0]        red_bits,
  input  wire  [nmtf_pkg::PORT_CH_W-1:0]        green_bits,
  input  wire  [nmtf_pkg::PORT_CH_W-1:0]        blue_bits,
  output logic [nmtf_pkg::PORT_CH_W-1:0]        out_red,
  output logic [nmtf_pkg::PORT_CH_W-1:0]        out_green,
  output logic [nmtf_pkg::PORT_CH_W-1:0]        out_blue,
  output logic                                  replaced,
  output logic [nmtf_pkg::POS_W-1:0]            source_x,
  output logic [nmtf_pkg::POS_W-1:0]            source_y
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int AW     = XW + YW;
  localparam int DEPTH  = 1 << AW;
  localparam int CW     = nmtf_pkg::COORD_W;
  localparam int COL_W  = 3 * CHANNEL_BITS;

  // Configuration registers
  logic [nmtf_pkg::RADIUS_W-1:0] search_radius;
  logic [nmtf_pkg::DIM_W-1:0]    image_width;
  logic [nmtf_pkg::DIM_W-1:0]    image_height;

  // Stores
  logic                 cov_mem [0:DEPTH-1];
  logic [COL_W-1:0]     col_mem [0:DEPTH-1];
  logic                 cov_q;
  logic [COL_W-1:0]     colour_q;

  // Query registers
  logic [nmtf_pkg::POS_W-1:0] qx;
  logic [nmtf_pkg::POS_W-1:0] qy;
  logic                       q_inside;
  logic [CW-1:0]              x0;
  logic [CW-1:0]              x1;
  logic [CW-1:0]              y1;
  logic                       win_empty;
  logic [CW-1:0]              px;
  logic [CW-1:0]              py;

  // Compare stage
  logic                        cand_q;
  logic [CW-1:0]               cx_q;
  logic [CW-1:0]               cy_q;
  logic [nmtf_pkg::SQ_W-1:0]   dx2_q;
  logic [nmtf_pkg::SQ_W-1:0]   dy2_q;
  logic                        found;
  logic [nmtf_pkg::DIST_W-1:0] best;
  logic [CW-1:0]               bx;
  logic [CW-1:0]               by;

  // Combinational helpers
  logic                        pos_inside;
  logic [nmtf_pkg::DIM_W-1:0]  w_last;
  logic [nmtf_pkg::DIM_W-1:0]  h_last;
  logic [CW-1:0]               sum_x;
  logic [CW-1:0]               sum_y;
  logic [CW-1:0]               x0_new;
  logic [CW-1:0]               x1_new;
  logic [CW-1:0]               y0_new;
  logic [CW-1:0]               y1_new;
  logic [CW+XW-1:0]            pos_x_w;
  logic [CW+YW-1:0]            pos_y_w;
  logic [CW+XW-1:0]            qx_w;
  logic [CW+YW-1:0]            qy_w;
  logic [CW+XW-1:0]            px_w;
  logic [CW+YW-1:0]            py_w;
  logic [CW+XW-1:0]            bx_w;
  logic [CW+YW-1:0]            by_w;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               own_addr;
  logic [AW-1:0]               scan_addr;
  logic [AW-1:0]               best_addr;
  logic [AW-1:0]               cov_addr;
  logic [AW-1:0]               col_addr;
  logic [CW:0]                 dx_raw;
  logic [CW:0]                 dy_raw;
  logic [CW:0]                 adx;
  logic [CW:0]                 ady;
  logic [nmtf_pkg::DIST_W-1:0] dist_sq;
  logic                        take;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_radius <= nmtf_pkg::RADIUS_RESET;
      image_width   <= nmtf_pkg::DIM_RESET;
      image_height  <= nmtf_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        nmtf_pkg::REG_SEARCH_RADIUS: search_radius <= cfg_data[nmtf_pkg::RADIUS_W-1:0];
        nmtf_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        nmtf_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp image size and derive last column and row
  always_comb begin
    if (image_width == '0) begin
      w_last = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_last = nmtf_pkg::DIM_W'(MAX_WIDTH - 1);
    end else begin
      w_last = image_width - 1'b1;
    end
    if (image_height == '0) begin
      h_last = '0;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_last = nmtf_pkg::DIM_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = image_height - 1'b1;
    end
  end

  // Clip the search window around the requested position
  always_comb begin
    sum_x  = CW'(pos_x) + CW'(search_radius);
    sum_y  = CW'(pos_y) + CW'(search_radius);
    x0_new = (pos_x >= search_radius) ? CW'(pos_x - search_radius) : '0;
    y0_new = (pos_y >= search_radius) ? CW'(pos_y - search_radius) : '0;
    x1_new = (sum_x <= w_last) ? sum_x : w_last;
    y1_new = (sum_y <= h_last) ? sum_y : h_last;
  end

  assign pos_inside = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);

  // Form store addresses as row and column fields
  always_comb begin
    pos_x_w   = {{XW{1'b0}}, 1'b0, pos_x};
    pos_y_w   = {{YW{1'b0}}, 1'b0, pos_y};
    qx_w      = {{XW{1'b0}}, 1'b0, qx};
    qy_w      = {{YW{1'b0}}, 1'b0, qy};
    px_w      = {{XW{1'b0}}, px};
    py_w      = {{YW{1'b0}}, py};
    bx_w      = {{XW{1'b0}}, bx};
    by_w      = {{YW{1'b0}}, by};
    wr_addr   = {pos_y_w[YW-1:0], pos_x_w[XW-1:0]};
    own_addr  = {qy_w[YW-1:0], qx_w[XW-1:0]};
    scan_addr = {py_w[YW-1:0], px_w[XW-1:0]};
    best_addr = {by_w[YW-1:0], bx_w[XW-1:0]};
    cov_addr  = cmd.scan_step ? scan_addr : own_addr;
    col_addr  = (cmd.fetch_colour && found) ? best_addr : own_addr;
  end

  // Write and read the coverage store
  always_ff @(posedge clk) begin
    if (cmd.wr_texel && pos_inside) begin
      cov_mem[wr_addr] <= (mask_byte == nmtf_pkg::FULL_MASK);
    end
    if (cmd.read_own || cmd.scan_step) begin
      cov_q <= cov_mem[cov_addr];
    end
  end

  // Write and read the colour store
  always_ff @(posedge clk) begin
    if (cmd.wr_texel && pos_inside) begin
      col_mem[wr_addr] <= {red_bits[CHANNEL_BITS-1:0], green_bits[CHANNEL_BITS-1:0],
                           blue_bits[CHANNEL_BITS-1:0]};
    end
    if (cmd.read_own || cmd.fetch_colour) begin
      colour_q <= col_mem[col_addr];
    end
  end

  // Latch the request and its window
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      qx        <= pos_x;
      qy        <= pos_y;
      q_inside  <= pos_inside;
      x0        <= x0_new;
      x1        <= x1_new;
      y1        <= y1_new;
      win_empty <= (x0_new > x1_new) || (y0_new > y1_new);
    end
  end

  // Advance the scan position in row-major order
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      px <= x0_new;
      py <= y0_new;
    end else if (cmd.scan_step) begin
      if (px == x1) begin
        px <= x0;
        py <= py + 1'b1;
      end else begin
        px <= px + 1'b1;
      end
    end
  end

  // Square the offsets alongside the coverage read
  always_comb begin
    dx_raw = {1'b0, px} - {2'b0, qx};
    dy_raw = {1'b0, py} - {2'b0, qy};
    adx    = dx_raw[CW] ? ((CW+1)'(0) - dx_raw) : dx_raw;
    ady    = dy_raw[CW] ? ((CW+1)'(0) - dy_raw) : dy_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_q <= 1'b0;
    end else begin
      cand_q <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    cx_q  <= px;
    cy_q  <= py;
    dx2_q <= adx[nmtf_pkg::POS_W-1:0] * adx[nmtf_pkg::POS_W-1:0];
    dy2_q <= ady[nmtf_pkg::POS_W-1:0] * ady[nmtf_pkg::POS_W-1:0];
  end

  // Keep the strictly nearest covered texel; earlier wins on ties
  assign dist_sq = nmtf_pkg::DIST_W'(dx2_q) + nmtf_pkg::DIST_W'(dy2_q);
  assign take    = cand_q && cov_q && (!found || (dist_sq < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.start_query) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best <= dist_sq;
      bx   <= cx_q;
      by   <= cy_q;
    end
  end

  // Report status to the controller
  always_comb begin
    status.outside   = !pos_inside;
    status.covered   = cov_q;
    status.win_empty = win_empty;
    status.scan_last = (px == x1) && (py == y1);
  end

  // Drive result fields
  always_comb begin
    if (q_inside) begin
      out_red   = nmtf_pkg::PORT_CH_W'(colour_q[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
      out_green = nmtf_pkg::PORT_CH_W'(colour_q[2*CHANNEL_BITS-1:CHANNEL_BITS]);
      out_blue  = nmtf_pkg::PORT_CH_W'(colour_q[CHANNEL_BITS-1:0]);
    end else begin
      out_red   = '0;
      out_green = '0;
      out_blue  = '0;
    end
    replaced = q_inside && found;
    source_x = replaced ? bx[nmtf_pkg::POS_W-1:0] : qx;
    source_y = replaced ? by[nmtf_pkg::POS_W-1:0] : qy;
  end

endmodule

`default_nettype wire

### rtl/nearest_masked_texel_fill.sv
// Sequence: a load completes in its accept cycle; a query beyond the store goes straight to
// reply, a covered texel passes lookup and check, an empty clipped window adds a colour fetch,
// else the clipped (2r+1)^2 square (1089 texels at radius 16) is scanned, one coverage read per
// cycle, then drain and fetch. Throughput: one query at a time; busy is high through the done
// cycle; loads every cycle while idle. The scan rate is set by the single coverage read port.
// Reset (rst, synchronous): controller idles, registers return to radius 16, size 256 x 256.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_masked_texel_fill_defines.svh"

module nearest_masked_texel_fill #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 32
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire                             command,
  input  wire  [nmtf_pkg::POS_W-1:0]      pos_x,
  input  wire  [nmtf_pkg::POS_W-1:0]      pos_y,
  input  wire  [7:0]                      mask_byte,
  input  wire  [nmtf_pkg::PORT_CH_W-1:0]  red_bits,
  input  wire  [nmtf_pkg::PORT_CH_W-1:0]  green_bits,
  input  wire  [nmtf_pkg::PORT_CH_W-1:0]  blue_bits,
  input  wire                             cfg_write,
  input  wire  [1:0]                      cfg_index,
  input  wire  [nmtf_pkg::CFG_W-1:0]      cfg_data,
  output logic                            done,
  output logic [nmtf_pkg::PORT_CH_W-1:0]  out_red,
  output logic [nmtf_pkg::PORT_CH_W-1:0]  out_green,
  output logic [nmtf_pkg::PORT_CH_W-1:0]  out_blue,
  output logic                            replaced,
  output logic [nmtf_pkg::POS_W-1:0]      source_x,
  output logic [nmtf_pkg::POS_W-1:0]      source_y
);

  nmtf_pkg::nmtf_cmd_t    cmd;
  nmtf_pkg::nmtf_status_t status;

  // Sequence each request
  nmtf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  // Store texels and search the window
  nmtf_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .mask_byte  (mask_byte),
    .red_bits   (red_bits),
    .green_bits (green_bits),
    .blue_bits  (blue_bits),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .replaced   (replaced),
    .source_x   (source_x),
    .source_y   (source_y)
  );

  // A load request completes in its accept cycle
  `NMTF_ASSERT_NEXT(a_load_single_cycle, clk, rst, start && !busy && (command == nmtf_pkg::CMD_LOAD), !busy && !done)
  // A query request always occupies the block afterwards
  `NMTF_ASSERT_NEXT(a_query_goes_busy, clk, rst, start && !busy && (command == nmtf_pkg::CMD_QUERY), busy)
  // One result per request, then return to idle
  `NMTF_ASSERT_NEXT(a_single_result, clk, rst, done, !done && !busy)
  // A result only appears while a request is in progress
  `NMTF_ASSERT_SAME(a_done_while_busy, clk, rst, done, busy)

endmodule

`default_nettype wire

### bench/nearest_masked_texel_fill_tb.sv
// Testbench for nearest_masked_texel_fill: load and query requests checked against a local predictor.
`timescale 1ns / 1ps

module nearest_masked_texel_fill_tb;
  import nmtf_pkg::*;

  localparam int MAX_DIM        = 256;
  localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 45;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                 cmd;
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
    logic [7:0]           mask;
    logic [PORT_CH_W-1:0] red;
    logic [PORT_CH_W-1:0] green;
    logic [PORT_CH_W-1:0] blue;
  } texel_req_t;

  typedef struct packed {
    logic [PORT_CH_W-1:0] red;
    logic [PORT_CH_W-1:0] green;
    logic [PORT_CH_W-1:0] blue;
    logic                 repl;
    logic [POS_W-1:0]     sx;
    logic [POS_W-1:0]     sy;
  } fill_result_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic                 command    = CMD_LOAD;
  logic [POS_W-1:0]     pos_x      = '0;
  logic [POS_W-1:0]     pos_y      = '0;
  logic [7:0]           mask_byte  = '0;
  logic [PORT_CH_W-1:0] red_bits   = '0;
  logic [PORT_CH_W-1:0] green_bits = '0;
  logic [PORT_CH_W-1:0] blue_bits  = '0;
  logic                 cfg_write  = 1'b0;
  logic [1:0]           cfg_index  = REG_SEARCH_RADIUS;
  logic [CFG_W-1:0]     cfg_data   = '0;
  wire                  busy;
  wire                  done;
  wire  [PORT_CH_W-1:0] out_red;
  wire  [PORT_CH_W-1:0] out_green;
  wire  [PORT_CH_W-1:0] out_blue;
  wire                  replaced;
  wire  [POS_W-1:0]     source_x;
  wire  [POS_W-1:0]     source_y;

  // Shadow of the block: registers, coverage, colours, and which texels were loaded
  logic [RADIUS_W-1:0]    radius_reg = RADIUS_RESET;
  logic [DIM_W-1:0]       width_reg  = DIM_RESET;
  logic [DIM_W-1:0]       height_reg = DIM_RESET;
  bit                     cov_mem    [STORE_DEPTH];
  bit [3*PORT_CH_W-1:0]   colour_mem [STORE_DEPTH];
  bit                     loaded_mem [STORE_DEPTH];

  fill_result_t expected_fills[$];
  int fail_count   = 0;
  int items_sent   = 0;
  int idle_pct     = 0;
  int cover_pct    = 50;
  int stall_cycles = 0;

  nearest_masked_texel_fill u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .mask_byte  (mask_byte),
    .red_bits   (red_bits),
    .green_bits (green_bits),
    .blue_bits  (blue_bits),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .replaced   (replaced),
    .source_x   (source_x),
    .source_y   (source_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Image size as the block sees it: zero acts as one, oversize acts as the maximum
  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Search window around (cx, cy), clipped to the image in use; may come out empty
  function automatic void clip_window(input int cx, input int cy,
                                      output int x0, output int y0,
                                      output int x1, output int y1);
    int r, w, h;
    r = int'(radius_reg);
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    x0 = (cx >= r) ? cx - r : 0;
    y0 = (cy >= r) ? cy - r : 0;
    x1 = (cx + r < w) ? cx + r : w - 1;
    y1 = (cy + r < h) ? cy + r : h - 1;
  endfunction

  // Nearest covered texel by squared distance, first in row-major order on ties
  function automatic fill_result_t predict_texel_fill(logic [POS_W-1:0] qx, logic [POS_W-1:0] qy);
    fill_result_t res;
    int cx, cy, x0, y0, x1, y1, px, py, bx, by, dx, dy;
    int unsigned d, best;
    bit found;
    cx = int'(qx);
    cy = int'(qy);
    {res.red, res.green, res.blue} = colour_mem[cy * MAX_DIM + cx];
    res.repl = 1'b0;
    res.sx = qx;
    res.sy = qy;
    if (!cov_mem[cy * MAX_DIM + cx]) begin
      clip_window(cx, cy, x0, y0, x1, y1);
      found = 1'b0;
      best = 0;
      bx = 0;
      by = 0;
      for (py = y0; py <= y1; py++) begin
        for (px = x0; px <= x1; px++) begin
          if (cov_mem[py * MAX_DIM + px]) begin
            dx = px - cx;
            dy = py - cy;
            d = dx * dx + dy * dy;
            if (!found || d < best) begin
              found = 1'b1;
              best = d;
              bx = px;
              by = py;
            end
          end
        end
      end
      if (found) begin
        {res.red, res.green, res.blue} = colour_mem[by * MAX_DIM + bx];
        res.repl = 1'b1;
        res.sx = POS_W'(bx);
        res.sy = POS_W'(by);
      end
    end
    return res;
  endfunction

  // Channel pattern with extra weight on all-zero and all-one
  function automatic logic [PORT_CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] rand_mask(int pct);
    if ($urandom_range(0, 99) < pct) return FULL_MASK;
    return 8'($urandom_range(0, 254));
  endfunction

  // Position near the image in use, now and then anywhere in the store
  task automatic pick_pos(output logic [POS_W-1:0] px, output logic [POS_W-1:0] py);
    int lw, lh;
    lw = eff_dim(width_reg) + 1;
    lh = eff_dim(height_reg) + 1;
    if (lw > MAX_DIM - 1) lw = MAX_DIM - 1;
    if (lh > MAX_DIM - 1) lh = MAX_DIM - 1;
    if ($urandom_range(0, 99) < 15) begin
      px = POS_W'($urandom_range(0, MAX_DIM - 1));
      py = POS_W'($urandom_range(0, MAX_DIM - 1));
    end else begin
      px = POS_W'($urandom_range(0, lw));
      py = POS_W'($urandom_range(0, lh));
    end
  endtask

  // Drive one request, hold it until accepted, then update the shadow
  task automatic send_request(input texel_req_t q);
    int a;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    command    <= q.cmd;
    pos_x      <= q.x;
    pos_y      <= q.y;
    mask_byte  <= q.mask;
    red_bits   <= q.red;
    green_bits <= q.green;
    blue_bits  <= q.blue;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = int'(q.y) * MAX_DIM + int'(q.x);
    if (q.cmd == CMD_LOAD) begin
      cov_mem[a]    = (q.mask == FULL_MASK);
      colour_mem[a] = {q.red, q.green, q.blue};
      loaded_mem[a] = 1'b1;
    end else begin
      expected_fills.push_back(predict_texel_fill(q.x, q.y));
    end
    items_sent++;
  endtask

  task automatic load_texel(input logic [POS_W-1:0] lx, input logic [POS_W-1:0] ly,
                            input logic [7:0] m, input logic [PORT_CH_W-1:0] r,
                            input logic [PORT_CH_W-1:0] g, input logic [PORT_CH_W-1:0] b);
    texel_req_t q;
    q.cmd   = CMD_LOAD;
    q.x     = lx;
    q.y     = ly;
    q.mask  = m;
    q.red   = r;
    q.green = g;
    q.blue  = b;
    send_request(q);
  endtask

  // Load whatever the query will read that was never written, then query
  task automatic query_texel(input logic [POS_W-1:0] qx, input logic [POS_W-1:0] qy);
    texel_req_t q;
    int x0, y0, x1, y1, px, py;
    if (!loaded_mem[int'(qy) * MAX_DIM + int'(qx)])
      load_texel(qx, qy, rand_mask(cover_pct), rand_channel(), rand_channel(), rand_channel());
    if (!cov_mem[int'(qy) * MAX_DIM + int'(qx)]) begin
      clip_window(int'(qx), int'(qy), x0, y0, x1, y1);
      for (py = y0; py <= y1; py++) begin
        for (px = x0; px <= x1; px++) begin
          if (!loaded_mem[py * MAX_DIM + px])
            load_texel(POS_W'(px), POS_W'(py), rand_mask(cover_pct),
                       rand_channel(), rand_channel(), rand_channel());
        end
      end
    end
    q.cmd   = CMD_QUERY;
    q.x     = qx;
    q.y     = qy;
    q.mask  = 8'($urandom);
    q.red   = $urandom();
    q.green = $urandom();
    q.blue  = $urandom();
    send_request(q);
  endtask

  // Hold off requests until every expected result has arrived
  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (expected_fills.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high so back-to-back writes need no extra cycle
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SEARCH_RADIUS: radius_reg = data[RADIUS_W-1:0];
      REG_IMAGE_WIDTH:   width_reg  = data;
      REG_IMAGE_HEIGHT:  height_reg = data;
      default: ;
    endcase
  endtask

  // Idle the block, poke the unused index, then write all three registers
  task automatic set_config(input logic [CFG_W-1:0] r_data, input logic [CFG_W-1:0] w_data,
                            input logic [CFG_W-1:0] h_data);
    drain_results;
    write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 511)));
    write_reg(REG_SEARCH_RADIUS, r_data);
    write_reg(REG_IMAGE_WIDTH, w_data);
    write_reg(REG_IMAGE_HEIGHT, h_data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [PORT_CH_W-1:0] want,
                               input logic [PORT_CH_W-1:0] got);
    if (want !== got) begin
      $error("%s expected %h actual %h", name, want, got);
      fail_count++;
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin : check_results
    fill_result_t want;
    if (!rst && done) begin
      if (expected_fills.size() == 0) begin
        $error("result with no request pending: source %0d,%0d", source_x, source_y);
        fail_count++;
      end else begin
        want = expected_fills.pop_front();
        compare_field("out_red", want.red, out_red);
        compare_field("out_green", want.green, out_green);
        compare_field("out_blue", want.blue, out_blue);
        compare_field("replaced", PORT_CH_W'(want.repl), PORT_CH_W'(replaced));
        compare_field("source_x", PORT_CH_W'(want.sx), PORT_CH_W'(source_x));
        compare_field("source_y", PORT_CH_W'(want.sy), PORT_CH_W'(source_y));
      end
    end
  end

  // Stop a hung run: count cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Covered texels at both store corners return themselves, extreme colours
  task automatic test_covered_extremes;
    load_texel(8'd0, 8'd0, FULL_MASK, '0, '0, '0);
    load_texel(8'd255, 8'd255, FULL_MASK, '1, '1, '1);
    query_texel(8'd0, 8'd0);
    query_texel(8'd255, 8'd255);
  endtask

  // Radius zero: an uncovered texel sees only itself and keeps its colour
  task automatic test_radius_zero;
    set_config(9'd0, 9'd256, 9'd256);
    load_texel(8'd255, 8'd0, 8'hfe, rand_channel(), rand_channel(), rand_channel());
    load_texel(8'd0, 8'd255, 8'h00, rand_channel(), rand_channel(), rand_channel());
    query_texel(8'd255, 8'd0);
    query_texel(8'd0, 8'd255);
  endtask

  // Four covered texels at distance one: the first in row-major order wins
  task automatic test_tie_break;
    int dx, dy;
    set_config(9'd1, 9'd256, 9'd256);
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        load_texel(POS_W'(10 + dx), POS_W'(10 + dy), (dx == 0 && dy == 0) ? 8'h7f : FULL_MASK,
                   rand_channel(), rand_channel(), rand_channel());
      end
    end
    query_texel(8'd10, 8'd10);
    // drop the winner; the next tie candidate takes over
    load_texel(8'd10, 8'd9, 8'h01, rand_channel(), rand_channel(), rand_channel());
    query_texel(8'd10, 8'd10);
  endtask

  // No covered texel in the window: the texel keeps its own colour
  task automatic test_no_neighbour;
    int dx, dy;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        load_texel(POS_W'(40 + dx), POS_W'(40 + dy), rand_mask(0),
                   rand_channel(), rand_channel(), rand_channel());
      end
    end
    query_texel(8'd40, 8'd40);
  endtask

  // Out-of-range register values, ignored radius bit, texels outside the image
  task automatic test_register_clamps;
    cover_pct = 60;
    set_config(9'h1ff, 9'd0, 9'd3);
    query_texel(8'd0, 8'd0);
    query_texel(8'd200, 8'd2);
    set_config(9'd3, 9'd511, 9'd0);
    query_texel(8'd254, 8'd0);
    // window lies wholly outside the image in use
    query_texel(8'd3, 8'd200);
    set_config(9'd2, 9'd256, 9'd257);
    query_texel(8'd255, 8'd255);
  endtask

  // Random phases of loads and queries over small images and varied settings
  task automatic test_random_traffic(input int sender_idle);
    int phase, goal;
    logic [CFG_W-1:0] r_data, w_data, h_data;
    logic [POS_W-1:0] px, py;
    idle_pct = sender_idle;
    for (phase = 0; phase < 4; phase++) begin
      case ($urandom_range(0, 9))
        7: begin
          r_data = $urandom_range(0, 1) ? 9'd255 : 9'h1ff;
          w_data = CFG_W'($urandom_range(1, 8));
          h_data = CFG_W'($urandom_range(1, 8));
        end
        8: begin
          r_data = CFG_W'($urandom_range(0, 5));
          w_data = $urandom_range(0, 1) ? 9'd256 : CFG_W'($urandom_range(257, 511));
          h_data = CFG_W'($urandom_range(0, 2));
        end
        9: begin
          r_data = CFG_W'($urandom_range(0, 5));
          w_data = CFG_W'($urandom_range(0, 2));
          h_data = $urandom_range(0, 1) ? 9'd256 : CFG_W'($urandom_range(257, 511));
        end
        default: begin
          r_data = CFG_W'($urandom_range(0, 6));
          w_data = CFG_W'($urandom_range(1, 12));
          h_data = CFG_W'($urandom_range(1, 12));
        end
      endcase
      case ($urandom_range(0, 4))
        0: cover_pct = 0;
        1: cover_pct = 10;
        2: cover_pct = 30;
        3: cover_pct = 60;
        default: cover_pct = 95;
      endcase
      set_config(r_data, w_data, h_data);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(0, 99) < 4) drain_results;
        pick_pos(px, py);
        if ($urandom_range(0, 99) < 55) query_texel(px, py);
        else load_texel(px, py, rand_mask(cover_pct), rand_channel(), rand_channel(),
                        rand_channel());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 32;
    test_covered_extremes;
    test_radius_zero;
    test_tie_break;
    test_no_neighbour;
    test_register_clamps;
    test_random_traffic(32);
    test_random_traffic(82);
    test_random_traffic(0);
    drain_results;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
